@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define MBP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed");

// Same-cycle implication.
`define MBP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

@@ sv/mbp_pkg.sv @@
package mbp_pkg;

   localparam int PORT_COUNT = 16;
   localparam int PORT_W     = 4;
   localparam int WORD_W     = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ST_SYSEX     = 8'hf0;
   localparam logic [7:0] ST_EOX       = 8'hf7;
   localparam logic [7:0] ST_REALTIME  = 8'hf8;
   localparam logic [7:0] ST_MIN       = 8'h80;
   localparam logic [7:0] ST_F4        = 8'hf4;
   localparam logic [7:0] ST_F5        = 8'hf5;
   localparam logic [7:0] ST_TUNE      = 8'hf6;
   localparam logic [7:0] ST_PROGRAM   = 8'hc0;
   localparam logic [7:0] ST_PRESSURE  = 8'hd0;
   localparam logic [7:0] ST_QFRAME    = 8'hf1;
   localparam logic [7:0] ST_SONG_SEL  = 8'hf3;
   localparam logic [7:0] CHAN_MASK    = 8'hf0;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [WORD_W-1:0] word;
   } mbp_item_type;

   typedef struct packed {
      logic         valid;
      mbp_item_type item;
   } mbp_push_type;

endpackage

@@ sv/mbp_parse.sv @@
`include "assert_macros.svh"

module mbp_parse
   import mbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [3:0]   port,
   input  logic [7:0]   data_byte,
   output mbp_push_type push
);

   logic [7:0] pend_ff [3];
   logic [7:0] pend_in [3];
   logic [1:0] count_ff, count_in;
   logic       sysex_ff, sysex_in;

   logic [WORD_W-1:0] word;
   logic              emit;
   logic              port_ok;
   logic [7:0]        status;
   logic [1:0]        after;

   assign port_ok = (32'(port) < PORT_COUNT);

   always_comb begin
      pend_in  = pend_ff;
      count_in = count_ff;
      sysex_in = sysex_ff;
      word     = '0;
      emit     = 1'b0;
      status   = (pend_ff[0] < ST_SYSEX) ? (pend_ff[0] & CHAN_MASK) : pend_ff[0];
      after    = (pend_ff[0] < ST_SYSEX) ? 2'd1 : 2'd0;

      if (data_byte >= ST_REALTIME) begin
         word = {24'd0, data_byte};
         emit = 1'b1;
      end else if (data_byte == ST_SYSEX) begin
         pend_in[0] = ST_SYSEX;
         count_in   = 2'd1;
         sysex_in   = 1'b1;
      end else if (data_byte == ST_EOX) begin
         case (count_ff)
            2'd0:    word = {24'd0, ST_EOX};
            2'd1:    word = {16'd0, ST_EOX, pend_ff[0]};
            2'd2:    word = {8'd0, ST_EOX, pend_ff[1], pend_ff[0]};
            default: word = {ST_EOX, pend_ff[2], pend_ff[1], pend_ff[0]};
         endcase
         emit     = 1'b1;
         sysex_in = 1'b0;
         count_in = 2'd0;
      end else if (data_byte >= ST_MIN) begin
         sysex_in = 1'b0;
         if (data_byte inside {ST_F4, ST_F5, ST_TUNE}) begin
            word     = {24'd0, data_byte};
            emit     = 1'b1;
            count_in = 2'd0;
         end else begin
            pend_in[0] = data_byte;
            count_in   = 2'd1;
         end
      end else if (sysex_ff) begin
         if (count_ff == 2'd3) begin
            word     = {data_byte, pend_ff[2], pend_ff[1], pend_ff[0]};
            emit     = 1'b1;
            count_in = 2'd0;
         end else begin
            pend_in[count_ff] = data_byte;
            count_in          = count_ff + 2'd1;
         end
      end else if (count_ff != 2'd0) begin
         if (status inside {ST_PROGRAM, ST_PRESSURE, ST_QFRAME, ST_SONG_SEL}) begin
            word     = {16'd0, data_byte, pend_ff[0]};
            emit     = 1'b1;
            count_in = after;
         end else if (count_ff == 2'd1) begin
            pend_in[1] = data_byte;
            count_in   = 2'd2;
         end else begin
            word     = {8'd0, data_byte, pend_ff[1], pend_ff[0]};
            emit     = 1'b1;
            count_in = after;
         end
      end
      // stray data bytes fall through with no state change
   end

   assign push.valid     = accept && emit && port_ok;
   assign push.item.port = port;
   assign push.item.word = word;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         sysex_ff <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         sysex_ff <= sysex_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '{default: 8'h00};
      end else if (accept) begin
         pend_ff <= pend_in;
      end
   end

   `MBP_ASSERT_IMP(a_eox_emits, clock, reset,
      accept && data_byte == ST_EOX && port_ok, push.valid)
   `MBP_ASSERT(a_sysex_start, clock, reset,
      !($past(accept) && $past(data_byte) == ST_SYSEX) || (sysex_ff && count_ff == 2'd1))

endmodule

@@ sv/mbp_queue.sv @@
`include "assert_macros.svh"

module mbp_queue
   import mbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mbp_push_type push,
   output logic         full,
   output logic         head_valid,
   output mbp_item_type head,
   input  logic         pop
);

   mbp_item_type            mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ff, wr_in;
   logic [QUEUE_AW-1:0]     rd_ff, rd_in;
   logic [QUEUE_CW-1:0]     count_ff, count_in;
   logic                    do_pop;

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push.valid) begin
         wr_in = (wr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ff] <= push.item;
      end
   end

   `MBP_ASSERT_IMP(a_no_overflow, clock, reset, push.valid, !full)
   `MBP_ASSERT(a_count_range, clock, reset, count_ff <= QUEUE_CW'(QUEUE_DEPTH))

endmodule

@@ sv/mbp_emit.sv @@
`include "assert_macros.svh"

module mbp_emit
   import mbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  mbp_item_type head,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output mbp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   mbp_item_type item_ff;

   // load a new item whenever the output slot is empty or being drained
   assign pop      = head_valid && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

   `MBP_ASSERT_IMP(a_pop_safe, clock, reset, pop, !valid_ff || rsp_tready)

endmodule

@@ sv/midi_byte_to_word_packer.sv @@
// MIDI byte stream to packed 32-bit event words.
// Input channel req_*: one raw MIDI byte and its port per item.
// Output channel rsp_*: zero or one event word per input item, with the port
// of the byte that completed it. The first byte sits in event_word[7:0].
// Realtime bytes, F4/F5/F6 and F7 produce a word at once; channel and system
// common messages produce one when complete (running status kept); SysEx data
// goes out four bytes to a word. Stray data bytes produce nothing.
// Throughput: one item per cycle. The parser decides each byte in the cycle it
// is accepted and pushes any word into a two-entry queue; an output register
// drains the queue. A word is registered in the queue and then in the output
// register before it shows on rsp_tvalid.
// When the receiver stalls, the output register holds its item, the queue
// fills, and req_tready drops once the queue is full.
// Reset (synchronous, active high) clears the parse state (no pending bytes,
// not in SysEx), empties the queue and drops rsp_tvalid.
module midi_byte_to_word_packer
   import mbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] port, [11:4] data_byte, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [3:0] out_port, [35:4] event_word, [39:36] zero
);

   logic         accept;
   logic         full;
   logic         head_valid;
   logic         pop;
   mbp_push_type push;
   mbp_item_type head;
   mbp_item_type rsp_item;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   mbp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .port      (req_tdata[3:0]),
      .data_byte (req_tdata[11:4]),
      .push      (push)
   );

   mbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   mbp_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {4'd0, rsp_item.word, rsp_item.port};

endmodule
